FILE: design/rdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

    localparam int VALUE_W = 31;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [DIGIT_W-1:0] DEC_LIMIT = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h61;
    localparam logic [CHAR_W-1:0]  CHAR_NONE = 7'h00;

    // Result of the serial divider, valid when done is high.
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } rdc_div_res_t;

    // Commands from the sequencer to the digit stack.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } rdc_stk_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DEC_LIMIT) begin
            ch = CHAR_ZERO + {1'b0, d};
        end else begin
            ch = CHAR_A + {1'b0, d} - {1'b0, DEC_LIMIT};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: design/radix_digit_converter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer to radix string converter.
// The input channel (s_valid, s_ready, s_value, s_radix) takes one item: a
// 31-bit non-negative number and a radix. The result channel (m_valid,
// m_ready, m_digit_char, m_last, m_bad_radix) returns the ASCII digits of
// the number in that radix, most significant first, with m_last on the
// final character. Zero gives the single character '0'. A radix outside
// 2 to 36 gives one item with m_bad_radix set and a zero character.
// Each digit costs one pass of the bit-serial divider, whose remainder is
// then handed over to the digit stack. The digits are then popped, each
// with a stack read followed by an output load. A zero value or a bad
// radix skips the divider.
// One item is worked on at a time; s_ready is high only while the block is
// idle, which it is again as soon as the final character sits in the output
// register, so a new item can be taken while that character still waits.
// A stall on m_ready holds the output register and pauses popping, with no
// loss. Synchronous active-low reset empties the stack and the output
// register and returns the sequencer to idle.
module radix_digit_converter_core #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [rdc_pkg::VALUE_W-1:0]  s_value,
    input  wire logic [rdc_pkg::RADIX_W-1:0]  s_radix,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [rdc_pkg::CHAR_W-1:0]   m_digit_char,
    output logic                              m_last,
    output logic                              m_bad_radix
);
    import rdc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_POP_READ,
        ST_POP_EMIT,
        ST_EMIT_ONE
    } state_t;

    state_t             state_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [RADIX_W-1:0] radix_reg;

    logic               m_valid_reg;
    logic [CHAR_W-1:0]  m_digit_char_reg;
    logic               m_last_reg;
    logic               m_bad_radix_reg;

    rdc_div_res_t       div_res;
    rdc_stk_ctrl_t      stk_ctrl;
    logic               div_start;
    logic [VALUE_W-1:0] div_dividend;
    logic [DIGIT_W-1:0] stk_digit;
    logic               stk_empty;

    logic               radix_bad;
    logic               out_free;
    logic               out_load;
    logic               quotient_zero;

    assign radix_bad     = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
    assign out_free      = !m_valid_reg || m_ready;
    assign out_load      = ((state_reg == ST_POP_EMIT) || (state_reg == ST_EMIT_ONE)) &&
                           out_free;
    assign quotient_zero = div_res.quotient == '0;

    // The first division starts from the input value; each further one
    // starts from the quotient that the previous one left.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = value_reg;
        unique case (state_reg)
            ST_CHECK: begin
                div_start = !radix_bad && (value_reg != '0);
            end
            ST_DIVIDE: begin
                div_start    = div_res.done && !quotient_zero;
                div_dividend = div_res.quotient;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign stk_ctrl.clear = state_reg == ST_CHECK;
    assign stk_ctrl.push  = (state_reg == ST_DIVIDE) && div_res.done;
    assign stk_ctrl.pop   = state_reg == ST_POP_READ;

    rdc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix_reg),
        .result   (div_res)
    );

    rdc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (stk_ctrl),
        .push_digit (div_res.remainder),
        .pop_digit  (stk_digit),
        .empty      (stk_empty)
    );

    // Sequencer and output register. The output register is released when
    // the receiver takes it; a load in the same cycle wins.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        value_reg <= s_value;
                        radix_reg <= s_radix;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (radix_bad || (value_reg == '0)) begin
                        state_reg <= ST_EMIT_ONE;
                    end else begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    if (div_res.done && quotient_zero) begin
                        state_reg <= ST_POP_READ;
                    end
                end
                ST_POP_READ: begin
                    state_reg <= ST_POP_EMIT;
                end
                ST_POP_EMIT: begin
                    if (out_free) begin
                        m_digit_char_reg <= digit_to_ascii(stk_digit);
                        m_last_reg       <= stk_empty;
                        m_bad_radix_reg  <= 1'b0;
                        state_reg        <= stk_empty ? ST_IDLE : ST_POP_READ;
                    end
                end
                ST_EMIT_ONE: begin
                    if (out_free) begin
                        m_digit_char_reg <= radix_bad ? CHAR_NONE : CHAR_ZERO;
                        m_last_reg       <= 1'b1;
                        m_bad_radix_reg  <= radix_bad;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = state_reg == ST_IDLE;
    assign m_valid      = m_valid_reg;
    assign m_digit_char = m_digit_char_reg;
    assign m_last       = m_last_reg;
    assign m_bad_radix  = m_bad_radix_reg;

    // A bad radix result is always a lone, final, zero character.
    a_bad_radix_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_radix |-> m_last && (m_digit_char == CHAR_NONE))
        else $error("bad radix result is not a final zero character");

    // Every normal character is a decimal digit or a lower-case letter.
    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_bad_radix |->
            ((m_digit_char >= 7'h30) && (m_digit_char <= 7'h39)) ||
            ((m_digit_char >= 7'h61) && (m_digit_char <= 7'h7a)))
        else $error("digit character out of range");

    // After taking an item the block is busy in the cycle that follows.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while converting");

    // The stack is drained whenever the block is idle.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> stk_empty)
        else $error("digit stack not empty while idle");

endmodule

`default_nettype wire

FILE: design/rdc_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, most significant first.
module rdc_divider (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [rdc_pkg::VALUE_W-1:0]  dividend,
    input  wire logic [rdc_pkg::RADIX_W-1:0]  divisor,
    output rdc_pkg::rdc_div_res_t             result
);
    import rdc_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [VALUE_W-1:0]   quo_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [RADIX_W-1:0]   divisor_reg;

    logic [DIGIT_W:0]     trial;
    logic                 fits;
    logic [DIGIT_W:0]     diff;
    logic [DIGIT_W-1:0]   rem_next;
    logic [VALUE_W-1:0]   quo_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[VALUE_W-1]};
        fits     = trial >= {1'b0, divisor_reg};
        diff     = trial - {1'b0, divisor_reg};
        rem_next = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        quo_next = {quo_reg[VALUE_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

`default_nettype wire

FILE: design/rdc_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// Digit stack: one push or one pop per cycle, popped digit registered.
module rdc_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  rdc_pkg::rdc_stk_ctrl_t            ctrl,
    input  wire logic [rdc_pkg::DIGIT_W-1:0]  push_digit,
    output logic      [rdc_pkg::DIGIT_W-1:0]  pop_digit,
    output logic                              empty
);
    import rdc_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    logic [DIGIT_W-1:0] mem [STACK_DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_dec;
    logic [DIGIT_W-1:0] pop_digit_reg;
    logic               can_push;

    assign count_dec = count_reg - 1'b1;
    assign can_push  = count_reg != FULL_CNT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.clear) begin
            count_reg <= '0;
        end else if (ctrl.push && can_push) begin
            count_reg <= count_reg + 1'b1;
        end else if (ctrl.pop && !empty) begin
            count_reg <= count_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push && can_push && !ctrl.clear) begin
            mem[count_reg[ADDR_W-1:0]] <= push_digit;
        end
        if (ctrl.pop) begin
            pop_digit_reg <= mem[count_dec[ADDR_W-1:0]];
        end
    end

    assign pop_digit = pop_digit_reg;
    assign empty     = count_reg == '0;

endmodule

`default_nettype wire
